// ----- hw/rtl/sphv_pkg.sv -----
// ----------------------------------------------------------------------------
// sphv_pkg
// Shared types, constants and helper functions of the sphere vertex generator.
// ----------------------------------------------------------------------------
package sphv_pkg;

    // index field width and number of low dividend bits in each divider
    localparam int IDX_W   = 8;
    localparam int DIV_LOW = 32;

    // initial cordic x, the limit gain in Q30
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032875;

    // configuration register indexes
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_SLICES = 2'd1;
    localparam logic [1:0] CFG_STACKS = 2'd2;

    // side data that travels with a word
    typedef struct packed {
        logic        oor;
        logic [15:0] vidx;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } t_side;

    // arctangent of 2^-k in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        v = 32'd0;
        case (k)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // clamp to [-16384, 16384]
    function automatic logic signed [15:0] sat14(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd16384) begin
            r = 16'sd16384;
        end else if (v < -24'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // clamp to [-65535, 65535]
    function automatic logic signed [16:0] satpos(input logic signed [23:0] v);
        logic signed [16:0] r;
        if (v > 24'sd65535) begin
            r = 17'sd65535;
        end else if (v < -24'sd65535) begin
            r = -17'sd65535;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/sphv_div.sv -----
// ----------------------------------------------------------------------------
// sphv_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor((num * 2^32 + low) / den) for num <= den.
// ----------------------------------------------------------------------------
module sphv_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [sphv_pkg::IDX_W-1:0]   i_num,
    input  logic [sphv_pkg::IDX_W-1:0]   i_den,
    input  logic [sphv_pkg::DIV_LOW-1:0] i_low,
    output logic [sphv_pkg::DIV_LOW:0]   o_quot
);
    localparam int N = sphv_pkg::DIV_LOW;
    localparam int W = sphv_pkg::IDX_W;

    logic [W-1:0] r_rem  [0:N];
    logic [N:0]   r_quot [0:N];
    logic [N-1:0] r_low  [0:N];
    logic [W-1:0] n_rem  [0:N];
    logic [N:0]   n_quot [0:N];
    logic [N-1:0] n_low  [0:N];

    // one compare and subtract per stage
    always_comb begin
        logic [W:0] t;
        logic       ge;
        ge        = (i_num >= i_den);
        n_rem[0]  = ge ? W'(i_num - i_den) : i_num;
        n_quot[0] = {N'(0), ge};
        n_low[0]  = i_low;
        for (int s = 1; s <= N; s++) begin
            t         = {r_rem[s-1], r_low[s-1][N-1]};
            ge        = (t >= {1'b0, i_den});
            n_rem[s]  = ge ? W'(t - {1'b0, i_den}) : t[W-1:0];
            n_quot[s] = {r_quot[s-1][N-1:0], ge};
            n_low[s]  = {r_low[s-1][N-2:0], 1'b0};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s <= N; s++) begin
                r_rem[s]  <= n_rem[s];
                r_quot[s] <= n_quot[s];
                r_low[s]  <= n_low[s];
            end
        end
    end

    assign o_quot = r_quot[N];

endmodule

// ----- hw/rtl/sphv_cordic.sv -----
// ----------------------------------------------------------------------------
// sphv_cordic
// Pipelined rotation-mode cordic, one iteration per stage, with quadrant
// fold-in and Q1.14 rounding on the way out.
// ----------------------------------------------------------------------------
module sphv_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);
    logic signed [32:0] r_x [0:STEPS];
    logic signed [32:0] r_y [0:STEPS];
    logic signed [31:0] r_z [0:STEPS];
    logic [1:0]         r_quad [0:STEPS];
    logic signed [32:0] n_x [0:STEPS];
    logic signed [32:0] n_y [0:STEPS];
    logic signed [31:0] n_z [0:STEPS];
    logic [1:0]         n_quad [0:STEPS];
    logic signed [15:0] n_sin, n_cos;

    // quadrant split and micro-rotations
    always_comb begin
        logic [32:0]        sum;
        logic signed [32:0] dx, dy;
        logic signed [31:0] at;
        sum       = {1'b0, i_phase} + 33'h020000000;
        n_quad[0] = sum[31:30];
        n_z[0]    = $signed({2'b00, sum[29:0]}) - 32'sd536870912;
        n_x[0]    = sphv_pkg::GAIN_Q30;
        n_y[0]    = 33'sd0;
        for (int s = 1; s <= STEPS; s++) begin
            dx        = r_y[s-1] >>> (s - 1);
            dy        = r_x[s-1] >>> (s - 1);
            at        = $signed(sphv_pkg::atan_turn(s - 1));
            n_quad[s] = r_quad[s-1];
            if (!r_z[s-1][31]) begin
                n_x[s] = r_x[s-1] - dx;
                n_y[s] = r_y[s-1] + dy;
                n_z[s] = r_z[s-1] - at;
            end else begin
                n_x[s] = r_x[s-1] + dx;
                n_y[s] = r_y[s-1] - dy;
                n_z[s] = r_z[s-1] + at;
            end
        end
    end

    // round to Q1.14 and rotate by quadrant
    always_comb begin
        logic signed [32:0] xr, yr;
        logic signed [15:0] c, s;
        xr = (r_x[STEPS] + 33'sd32768) >>> 16;
        yr = (r_y[STEPS] + 33'sd32768) >>> 16;
        c  = sphv_pkg::sat14(24'(xr));
        s  = sphv_pkg::sat14(24'(yr));
        case (r_quad[STEPS])
            2'd1:    begin n_cos = -s; n_sin = c;  end
            2'd2:    begin n_cos = -c; n_sin = -s; end
            2'd3:    begin n_cos = s;  n_sin = -c; end
            default: begin n_cos = c;  n_sin = s;  end
        endcase
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s <= STEPS; s++) begin
                r_x[s]    <= n_x[s];
                r_y[s]    <= n_y[s];
                r_z[s]    <= n_z[s];
                r_quad[s] <= n_quad[s];
            end
            o_sin <= n_sin;
            o_cos <= n_cos;
        end
    end

endmodule

// ----- hw/rtl/sphv_shade.sv -----
// ----------------------------------------------------------------------------
// sphv_shade
// Vertex arithmetic: normal and position products over three stages, the
// last of which is the output register.
// ----------------------------------------------------------------------------
module sphv_shade (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [15:0]           i_radius,
    input  logic signed [15:0]    i_sin_phi,
    input  logic signed [15:0]    i_cos_phi,
    input  logic signed [15:0]    i_sin_theta,
    input  logic signed [15:0]    i_cos_theta,
    input  sphv_pkg::t_side       i_side,
    output logic signed [16:0]    o_pos_x,
    output logic signed [16:0]    o_pos_y,
    output logic signed [16:0]    o_pos_z,
    output logic signed [15:0]    o_normal_x,
    output logic signed [15:0]    o_normal_y,
    output logic signed [15:0]    o_normal_z,
    output logic signed [15:0]    o_tangent_x,
    output logic signed [15:0]    o_tangent_z,
    output logic [16:0]           o_tex_u,
    output logic [16:0]           o_tex_v,
    output logic [15:0]           o_vertex_index,
    output logic                  o_out_of_range
);
    logic signed [16:0] rs;

    logic signed [31:0] r_a_pxc, r_a_pxs;
    logic signed [32:0] r_a_pyr;
    logic signed [15:0] r_a_cp, r_a_st, r_a_ct;
    sphv_pkg::t_side    r_a_side;

    logic signed [15:0] r_b_nx, r_b_nz;
    logic signed [16:0] r_b_posy;
    logic signed [48:0] r_b_pxr, r_b_pzr;
    logic signed [15:0] r_b_cp, r_b_st, r_b_ct;
    sphv_pkg::t_side    r_b_side;

    assign rs = $signed({1'b0, i_radius});

    // first products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pxc  <= 32'(i_sin_phi) * 32'(i_cos_theta);
            r_a_pxs  <= 32'(i_sin_phi) * 32'(i_sin_theta);
            r_a_pyr  <= 33'(rs) * 33'(i_cos_phi);
            r_a_cp   <= i_cos_phi;
            r_a_st   <= i_sin_theta;
            r_a_ct   <= i_cos_theta;
            r_a_side <= i_side;
        end
    end

    // normals, pos y and radius products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_nx   <= sphv_pkg::sat14(24'((r_a_pxc + 32'sd8192) >>> 14));
            r_b_nz   <= sphv_pkg::sat14(24'((r_a_pxs + 32'sd8192) >>> 14));
            r_b_posy <= sphv_pkg::satpos(24'((r_a_pyr + 33'sd8192) >>> 14));
            r_b_pxr  <= 49'(rs) * 49'(r_a_pxc);
            r_b_pzr  <= 49'(rs) * 49'(r_a_pxs);
            r_b_cp   <= r_a_cp;
            r_b_st   <= r_a_st;
            r_b_ct   <= r_a_ct;
            r_b_side <= r_a_side;
        end
    end

    // output register, zero when the index is out of range
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_out_of_range <= r_b_side.oor;
            if (r_b_side.oor) begin
                o_pos_x        <= '0;
                o_pos_y        <= '0;
                o_pos_z        <= '0;
                o_normal_x     <= '0;
                o_normal_y     <= '0;
                o_normal_z     <= '0;
                o_tangent_x    <= '0;
                o_tangent_z    <= '0;
                o_tex_u        <= '0;
                o_tex_v        <= '0;
                o_vertex_index <= '0;
            end else begin
                o_pos_x        <= sphv_pkg::satpos(
                                      24'((r_b_pxr + 49'sd134217728) >>> 28));
                o_pos_y        <= r_b_posy;
                o_pos_z        <= sphv_pkg::satpos(
                                      24'((r_b_pzr + 49'sd134217728) >>> 28));
                o_normal_x     <= r_b_nx;
                o_normal_y     <= r_b_cp;
                o_normal_z     <= r_b_nz;
                o_tangent_x    <= -r_b_st;
                o_tangent_z    <= r_b_ct;
                o_tex_u        <= r_b_side.tex_u;
                o_tex_v        <= r_b_side.tex_v;
                o_vertex_index <= r_b_side.vidx;
            end
        end
    end

endmodule

// ----- hw/rtl/sphere_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// sphere_vertex_generator
// One UV sphere vertex (position, normal, tangent, uv, index) per grid point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one grid point word
//   (stack index, slice index). Output channel o_out_valid / i_out_ready
//   carries one vertex word per input word, in order.
//   Radius, slice count and stack count are written through the i_cfg_*
//   port; the user must do so only while no word is in flight, as the
//   block itself does not enforce it. The pipeline is an input register,
//   33 divider stages (one quotient bit each), CORDIC_STEPS + 2 cordic
//   stages and three vertex arithmetic stages ending in the output register.
//   Throughput is one word per cycle unless the receiver stalls.
//   When the receiver stalls the whole pipeline holds and o_in_ready drops;
//   nothing is lost or repeated. Bubbles still advance while o_out_valid
//   is low.
//   Reset clears all valid bits and loads radius 1.0, 16 slices, 16 stacks.
// ----------------------------------------------------------------------------
module sphere_vertex_generator #(
    parameter int COUNT_BITS   = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_stack_index,
    input  logic [7:0]         i_slice_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic signed [15:0] o_tangent_x,
    output logic signed [15:0] o_tangent_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [15:0]        o_vertex_index,
    output logic               o_out_of_range
);
    localparam int DIV_LAT = sphv_pkg::DIV_LOW + 1;
    localparam int COR_LAT = CORDIC_STEPS + 2;
    localparam int DEPTH   = 1 + DIV_LAT + COR_LAT + 3;

    logic [15:0]           r_radius;
    logic [COUNT_BITS-1:0] r_slice_count, r_stack_count;
    logic [7:0]            slices, stacks;

    logic             en;
    logic [DEPTH-1:0] r_vld;

    logic [7:0]       r_s0_i, r_s0_j;
    logic             r_s0_oor;
    logic [15:0]      r_s0_vidx;
    logic             n_oor;
    logic [15:0]      n_vidx;

    logic             r_pre_oor  [0:DIV_LAT-1];
    logic [15:0]      r_pre_vidx [0:DIV_LAT-1];
    sphv_pkg::t_side  r_post     [0:COR_LAT-1];
    sphv_pkg::t_side  n_post0;

    logic [sphv_pkg::DIV_LOW:0]   q_phi, q_theta, q_v, q_u;
    logic [sphv_pkg::DIV_LOW-1:0] uv_low_s, uv_low_t;
    logic signed [15:0]           sin_phi, cos_phi, sin_theta, cos_theta;

    assign slices   = 8'(r_slice_count);
    assign stacks   = 8'(r_stack_count);
    assign uv_low_s = {8'd0, 8'(slices >> 1), 16'd0};
    assign uv_low_t = {8'd0, 8'(stacks >> 1), 16'd0};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= 16'd256;
            r_slice_count <= COUNT_BITS'(16);
            r_stack_count <= COUNT_BITS'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sphv_pkg::CFG_RADIUS: r_radius      <= i_cfg_data;
                sphv_pkg::CFG_SLICES: r_slice_count <= i_cfg_data[COUNT_BITS-1:0];
                sphv_pkg::CFG_STACKS: r_stack_count <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // global advance: hold everything while the output word waits
    assign en         = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    // range check and vertex index of the incoming word
    assign n_oor  = (slices == 8'd0) || (stacks == 8'd0) ||
                    (i_stack_index > stacks) || (i_slice_index > slices);
    assign n_vidx = 16'(i_stack_index) * (16'(slices) + 16'd1) + 16'(i_slice_index);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_i    <= i_stack_index;
            r_s0_j    <= i_slice_index;
            r_s0_oor  <= n_oor;
            r_s0_vidx <= n_vidx;
        end
    end

    // angle phases and uv quotients
    sphv_div u_div_phi (
        .i_clk(i_clk), .i_en(en), .i_num(r_s0_i), .i_den(stacks),
        .i_low('0), .o_quot(q_phi)
    );
    sphv_div u_div_theta (
        .i_clk(i_clk), .i_en(en), .i_num(r_s0_j), .i_den(slices),
        .i_low('0), .o_quot(q_theta)
    );
    sphv_div u_div_v (
        .i_clk(i_clk), .i_en(en), .i_num(r_s0_i), .i_den(stacks),
        .i_low(uv_low_t), .o_quot(q_v)
    );
    sphv_div u_div_u (
        .i_clk(i_clk), .i_en(en), .i_num(r_s0_j), .i_den(slices),
        .i_low(uv_low_s), .o_quot(q_u)
    );

    // side data delay lines
    always_comb begin
        n_post0.oor   = r_pre_oor[DIV_LAT-1];
        n_post0.vidx  = r_pre_vidx[DIV_LAT-1];
        n_post0.tex_u = q_u[sphv_pkg::DIV_LOW:16];
        n_post0.tex_v = q_v[sphv_pkg::DIV_LOW:16];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre_oor[0]  <= r_s0_oor;
            r_pre_vidx[0] <= r_s0_vidx;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_pre_oor[s]  <= r_pre_oor[s-1];
                r_pre_vidx[s] <= r_pre_vidx[s-1];
            end
            r_post[0] <= n_post0;
            for (int s = 1; s < COR_LAT; s++) begin
                r_post[s] <= r_post[s-1];
            end
        end
    end

    // sine and cosine of both angles
    sphv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
        .i_clk(i_clk), .i_en(en), .i_phase(q_phi[sphv_pkg::DIV_LOW:1]),
        .o_sin(sin_phi), .o_cos(cos_phi)
    );
    sphv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
        .i_clk(i_clk), .i_en(en), .i_phase(q_theta[sphv_pkg::DIV_LOW-1:0]),
        .o_sin(sin_theta), .o_cos(cos_theta)
    );

    // vertex arithmetic and output register
    sphv_shade u_shade (
        .i_clk(i_clk), .i_en(en), .i_radius(r_radius),
        .i_sin_phi(sin_phi), .i_cos_phi(cos_phi),
        .i_sin_theta(sin_theta), .i_cos_theta(cos_theta),
        .i_side(r_post[COR_LAT-1]),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_tangent_x(o_tangent_x), .o_tangent_z(o_tangent_z),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v),
        .o_vertex_index(o_vertex_index), .o_out_of_range(o_out_of_range)
    );

`ifndef SYNTHESIS
    // a waiting output word blocks new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // out of range words carry zero payload
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |->
        (o_pos_x == 17'sd0 && o_pos_y == 17'sd0 && o_tex_u == 17'd0 &&
         o_tex_v == 17'd0 && o_vertex_index == 16'd0 && o_normal_y == 16'sd0))
        else $error("out of range word with nonzero payload");

    // uv never exceeds one
    a_uv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tex_u <= 17'd65536 && o_tex_v <= 17'd65536))
        else $error("uv beyond one");

    // unit vector components stay clamped
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384 &&
                         o_tangent_z <= 16'sd16384 && o_tangent_z >= -16'sd16384))
        else $error("unit component out of range");
`endif

endmodule

// ----- tb/sphv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphv_checker
// Watches both channels of the sphere vertex generator, predicts each vertex
// from the grid point and the current register values, and compares every
// field of every output word in order.
// ----------------------------------------------------------------------------
module sphv_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_stack_index,
    input  logic [7:0]         i_slice_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [16:0] i_pos_x,
    input  logic signed [16:0] i_pos_y,
    input  logic signed [16:0] i_pos_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_tangent_x,
    input  logic signed [15:0] i_tangent_z,
    input  logic [16:0]        i_tex_u,
    input  logic [16:0]        i_tex_v,
    input  logic [15:0]        i_vertex_index,
    input  logic               i_out_of_range,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int STEPS = 16;

    typedef struct {
        logic signed [16:0] px, py, pz;
        logic signed [15:0] nx, ny, nz, tx, tz;
        logic [16:0]        u, v;
        logic [15:0]        vidx;
        logic               oor;
    } t_vertex;

    t_vertex    vertex_q[$];
    logic [15:0] radius_r;
    logic [7:0]  slices_r, stacks_r;

    assign o_pending = vertex_q.size();

    // floor(v / 2^s + 1/2)
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // cordic sine and cosine of a phase in 2^-32 turns, Q1.14
    task automatic trig_q14(input longint phase, output longint s_o, output longint c_o);
        longint ph, q4, z, x, y, dx, dy, c, s;
        ph = phase & 64'hFFFF_FFFF;
        q4 = (ph + (64'sd1 <<< 29)) >>> 30;
        z  = ph - (q4 <<< 30);
        x  = longint'(sphv_pkg::GAIN_Q30);
        y  = 0;
        for (int k = 0; k < STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(sphv_pkg::atan_turn(k));
            end else begin
                x += dx; y -= dy; z += longint'(sphv_pkg::atan_turn(k));
            end
        end
        c = clip(rnd_shift(x, 16), 16384);
        s = clip(rnd_shift(y, 16), 16384);
        case (q4 & 3)
            0: begin c_o = c;  s_o = s;  end
            1: begin c_o = -s; s_o = c;  end
            2: begin c_o = -c; s_o = -s; end
            default: begin c_o = s; s_o = -c; end
        endcase
    endtask

    task automatic predict_vertex(input logic [7:0] si, input logic [7:0] sj,
                                  output t_vertex e);
        longint i, j, sp, cp, st, ct, r, ns, nl;
        i  = longint'(si);
        j  = longint'(sj);
        ns = longint'(slices_r);
        nl = longint'(stacks_r);
        e  = '{default: 0};
        if (ns == 0 || nl == 0 || i > nl || j > ns) begin
            e.oor = 1'b1;
        end else begin
            trig_q14((i <<< 31) / nl, sp, cp);
            trig_q14((j <<< 32) / ns, st, ct);
            r      = longint'(radius_r);
            e.px   = 17'(clip(rnd_shift(r * sp * ct, 28), 65535));
            e.py   = 17'(clip(rnd_shift(r * cp, 14), 65535));
            e.pz   = 17'(clip(rnd_shift(r * sp * st, 28), 65535));
            e.nx   = 16'(clip(rnd_shift(sp * ct, 14), 16384));
            e.ny   = 16'(cp);
            e.nz   = 16'(clip(rnd_shift(sp * st, 14), 16384));
            e.tx   = 16'(-st);
            e.tz   = 16'(ct);
            e.u    = 17'((j * 65536 + ns / 2) / ns);
            e.v    = 17'((i * 65536 + nl / 2) / nl);
            e.vidx = 16'(i * (ns + 1) + j);
        end
    endtask

    // register shadow, input prediction and output comparison
    always @(posedge i_clk) begin
        t_vertex e;
        if (!i_rst_n) begin
            radius_r     = 16'd256;
            slices_r     = 8'd16;
            stacks_r     = 8'd16;
            o_fail_count = 0;
            vertex_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (vertex_q.size() == 0) begin
                    $error("unexpected output word");
                    o_fail_count++;
                end else begin
                    e = vertex_q.pop_front();
                    if (i_pos_x !== e.px) begin
                        $error("pos_x exp %0d got %0d", e.px, i_pos_x); o_fail_count++;
                    end
                    if (i_pos_y !== e.py) begin
                        $error("pos_y exp %0d got %0d", e.py, i_pos_y); o_fail_count++;
                    end
                    if (i_pos_z !== e.pz) begin
                        $error("pos_z exp %0d got %0d", e.pz, i_pos_z); o_fail_count++;
                    end
                    if (i_normal_x !== e.nx) begin
                        $error("normal_x exp %0d got %0d", e.nx, i_normal_x); o_fail_count++;
                    end
                    if (i_normal_y !== e.ny) begin
                        $error("normal_y exp %0d got %0d", e.ny, i_normal_y); o_fail_count++;
                    end
                    if (i_normal_z !== e.nz) begin
                        $error("normal_z exp %0d got %0d", e.nz, i_normal_z); o_fail_count++;
                    end
                    if (i_tangent_x !== e.tx) begin
                        $error("tangent_x exp %0d got %0d", e.tx, i_tangent_x);
                        o_fail_count++;
                    end
                    if (i_tangent_z !== e.tz) begin
                        $error("tangent_z exp %0d got %0d", e.tz, i_tangent_z);
                        o_fail_count++;
                    end
                    if (i_tex_u !== e.u) begin
                        $error("tex_u exp %0d got %0d", e.u, i_tex_u); o_fail_count++;
                    end
                    if (i_tex_v !== e.v) begin
                        $error("tex_v exp %0d got %0d", e.v, i_tex_v); o_fail_count++;
                    end
                    if (i_vertex_index !== e.vidx) begin
                        $error("vertex_index exp %0d got %0d", e.vidx, i_vertex_index);
                        o_fail_count++;
                    end
                    if (i_out_of_range !== e.oor) begin
                        $error("out_of_range exp %0d got %0d", e.oor, i_out_of_range);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_vertex(i_stack_index, i_slice_index, e);
                vertex_q = {vertex_q, e};
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sphv_pkg::CFG_RADIUS: radius_r = i_cfg_data;
                    sphv_pkg::CFG_SLICES: slices_r = i_cfg_data[7:0];
                    sphv_pkg::CFG_STACKS: stacks_r = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives grid points into the sphere vertex generator under several register
// settings and idling patterns; the checker predicts and compares each word.
// ----------------------------------------------------------------------------
module tb_top;

    logic               i_clk, i_rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid, in_ready, out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         stack_index, slice_index;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] normal_x, normal_y, normal_z, tangent_x, tangent_z;
    logic [16:0]        tex_u, tex_v;
    logic [15:0]        vertex_index;
    logic               out_of_range;
    int                 fail_count, pending;
    int                 send_idle_pct, recv_stall_pct;
    logic               hold_go;
    logic               hold_seen = 1'b0;
    int                 hold_cnt = 0;
    logic [7:0]         slices_now, stacks_now;

    sphere_vertex_generator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_stack_index(stack_index), .i_slice_index(slice_index),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_pos_z(pos_z),
        .o_normal_x(normal_x), .o_normal_y(normal_y), .o_normal_z(normal_z),
        .o_tangent_x(tangent_x), .o_tangent_z(tangent_z),
        .o_tex_u(tex_u), .o_tex_v(tex_v),
        .o_vertex_index(vertex_index), .o_out_of_range(out_of_range)
    );

    sphv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_stack_index(stack_index), .i_slice_index(slice_index),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_normal_x(normal_x), .i_normal_y(normal_y), .i_normal_z(normal_z),
        .i_tangent_x(tangent_x), .i_tangent_z(tangent_z),
        .i_tex_u(tex_u), .i_tex_v(tex_v),
        .i_vertex_index(vertex_index), .i_out_of_range(out_of_range),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stalls, or one long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt  <= 300;
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == sphv_pkg::CFG_SLICES) slices_now = val[7:0];
        if (idx == sphv_pkg::CFG_STACKS) stacks_now = val[7:0];
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // one grid point word, with random idle cycles before it
    task automatic send_point(input logic [7:0] i, input logic [7:0] j);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid    = 1'b1;
        stack_index = i;
        slice_index = j;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly in range, a few beyond the stack count, now and then any value
    task automatic send_random(input int n);
        logic [7:0] i, j;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: begin i = 8'($urandom); j = 8'($urandom); end
                1: begin
                    i = (stacks_now == 8'hFF) ? 8'hFF : 8'(stacks_now + 8'd1);
                    j = 8'($urandom_range(slices_now));
                end
                default: begin
                    i = 8'($urandom_range(stacks_now));
                    j = 8'($urandom_range(slices_now));
                end
            endcase
            send_point(i, j);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = sphv_pkg::CFG_RADIUS;
        cfg_data       = '0;
        in_valid       = 1'b0;
        stack_index    = '0;
        slice_index    = '0;
        hold_go        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        slices_now     = 8'd16;
        stacks_now     = 8'd16;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: poles, seam, extremes and out of range at reset counts
        send_point(8'd0, 8'd0);
        send_point(8'd16, 8'd0);
        send_point(8'd8, 8'd16);
        send_point(8'd8, 8'd4);
        send_point(8'd4, 8'd12);
        send_point(8'd17, 8'd3);
        send_point(8'd3, 8'd17);
        send_point(8'hFF, 8'hFF);
        send_point(8'hAA, 8'h55);
        send_point(8'h55, 8'hAA);
        drain();
        write_reg(sphv_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(sphv_pkg::CFG_SLICES, 16'd255);
        write_reg(sphv_pkg::CFG_STACKS, 16'd255);
        // an index past the last register is ignored
        write_reg(sphv_pkg::CFG_STACKS + 2'd1, 16'h1234);
        send_point(8'd255, 8'd255);
        send_point(8'd128, 8'd64);
        send_point(8'd1, 8'd255);
        send_point(8'd127, 8'd191);
        send_point(8'd255, 8'd0);
        drain();
        write_reg(sphv_pkg::CFG_RADIUS, 16'd0);
        write_reg(sphv_pkg::CFG_SLICES, 16'd1);
        write_reg(sphv_pkg::CFG_STACKS, 16'd1);
        send_point(8'd0, 8'd1);
        send_point(8'd1, 8'd0);
        send_point(8'd1, 8'd1);
        send_point(8'd2, 8'd0);
        drain();
        write_reg(sphv_pkg::CFG_SLICES, 16'd0);
        send_point(8'd0, 8'd0);
        drain();
        write_reg(sphv_pkg::CFG_SLICES, 16'd7);
        write_reg(sphv_pkg::CFG_STACKS, 16'd0);
        send_point(8'd0, 8'd0);
        drain();

        // random phases with different settings and idling
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(sphv_pkg::CFG_RADIUS, (ph == 1) ? 16'hFFFF : 16'($urandom));
            write_reg(sphv_pkg::CFG_SLICES,
                      (ph == 2) ? 16'd255 : 16'($urandom_range(255, 1)));
            write_reg(sphv_pkg::CFG_STACKS,
                      (ph == 3) ? 16'd1 : 16'($urandom_range(255, 1)));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (ph == 4) hold_go = 1'b1;
            send_random(45);
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
